### hw/rtl/rssv_pkg.sv
`default_nettype none

package rssv_pkg;

    localparam logic [5:0] FIELDS_PER_ROW = 6'd36;
    localparam logic [5:0] SCHED_LEN      = 6'd36;

    localparam logic [31:0] MAGIC_WORD_RST = 32'h3153_5452;
    localparam logic [31:0] MAX_ROWS_RST   = 32'd1000000;

    localparam logic [0:0] CFG_MAGIC_WORD = 1'b0;
    localparam logic [0:0] CFG_MAX_ROWS   = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_COUNT = 3'd1,
        PH_FIELD = 3'd2,
        PH_LEN   = 3'd3,
        PH_STR   = 3'd4,
        PH_NUM   = 3'd5,
        PH_DONE  = 3'd6,
        PH_ERR   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        FT_STR   = 3'd0,
        FT_NUM   = 3'd1,
        FT_BOOL  = 3'd2,
        FT_NBOOL = 3'd3,
        FT_NSTR  = 3'd4,
        FT_NNUM  = 3'd5
    } ftype_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_OK    = 3'd1,
        ST_MAGIC = 3'd2,
        ST_COUNT = 3'd3,
        ST_ROW   = 3'd4,
        ST_TRAIL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_TAG     = 2'd1,
        ROLE_CONTENT = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] row_number;
        logic [5:0]  field_number;
        role_t       byte_role;
        logic [7:0]  byte_value;
        logic        payload_done;
    } result_t;

    localparam ftype_t SCHED_TABLE [0:35] = '{
        FT_STR,   FT_STR,   FT_STR,  FT_STR,  FT_STR,  FT_STR,  FT_NUM,  FT_STR,  FT_NUM,
        FT_STR,   FT_STR,   FT_NBOOL, FT_NBOOL, FT_BOOL, FT_BOOL, FT_BOOL, FT_BOOL, FT_STR,
        FT_STR,   FT_STR,   FT_NUM,  FT_STR,  FT_NUM,  FT_NUM,  FT_NUM,  FT_STR,  FT_NSTR,
        FT_NSTR,  FT_STR,   FT_STR,  FT_STR,  FT_NNUM, FT_BOOL, FT_NUM,  FT_STR,  FT_STR
    };

    // schedule repeats past its length
    function automatic ftype_t sched_type(input logic [5:0] pos);
        logic [5:0] idx;
        idx = (pos < SCHED_LEN) ? pos : (pos - SCHED_LEN);
        return SCHED_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rssv_in_reg.sv
`default_nettype none

module rssv_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_data_byte,
    input  wire logic           s_end_of_payload,
    input  wire logic           advance,
    output logic                item_valid,
    output rssv_pkg::item_t     item
);
    import rssv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data_byte      <= s_data_byte;
            item_reg.end_of_payload <= s_end_of_payload;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rssv_core.sv
`default_nettype none

module rssv_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [0:0]     cfg_index,
    input  wire logic [31:0]    cfg_wr_data,
    input  wire rssv_pkg::item_t in_item,
    input  wire logic           advance,
    output rssv_pkg::result_t   result
);
    import rssv_pkg::*;

    logic [31:0] magic_word_reg;
    logic [31:0] max_rows_reg;

    phase_t      phase_reg,        phase_next;
    logic [2:0]  byte_in_item_reg, byte_in_item_next;
    logic [5:0]  field_pos_reg,    field_pos_next;
    logic [31:0] string_left_reg,  string_left_next;
    logic [31:0] length_shift_reg, length_shift_next;
    logic [31:0] row_pos_reg,      row_pos_next;
    logic [31:0] row_total_reg,    row_total_next;
    status_t     error_held_reg,   error_held_next;

    ftype_t      ftype;
    logic [7:0]  b;
    logic        last;
    logic [4:0]  byte_sh;
    logic [31:0] b_shifted;
    logic [31:0] count_full;
    logic [31:0] len_full;
    logic [31:0] str_dec;
    logic [5:0]  fld_inc;
    logic [31:0] row_inc;
    logic [7:0]  magic_byte;
    logic        do_finish;
    logic        do_fail;
    status_t     fail_code;

    assign b          = in_item.data_byte;
    assign last       = in_item.end_of_payload;
    assign ftype      = sched_type(field_pos_reg);
    assign byte_sh    = {byte_in_item_reg[1:0], 3'b000};
    assign b_shifted  = {24'd0, b} << byte_sh;
    assign count_full = row_total_reg | b_shifted;
    assign len_full   = length_shift_reg | b_shifted;
    assign str_dec    = string_left_reg - 32'd1;
    assign fld_inc    = field_pos_reg + 6'd1;
    assign row_inc    = row_pos_reg + 32'd1;
    assign magic_byte = magic_word_reg[byte_sh +: 8];

    always_comb begin
        phase_next          = phase_reg;
        byte_in_item_next   = byte_in_item_reg;
        field_pos_next      = field_pos_reg;
        string_left_next    = string_left_reg;
        length_shift_next   = length_shift_reg;
        row_pos_next        = row_pos_reg;
        row_total_next      = row_total_reg;
        error_held_next     = error_held_reg;
        do_finish           = 1'b0;
        do_fail             = 1'b0;
        fail_code           = ST_ROW;

        result.status       = ST_RUN;
        result.row_number   = row_pos_reg;
        result.field_number = field_pos_reg;
        result.byte_role    = ROLE_IGNORED;
        result.byte_value   = b;
        result.payload_done = last;

        unique case (phase_reg)
            PH_MAGIC: begin
                result.byte_role    = ROLE_HEADER;
                result.row_number   = '0;
                result.field_number = '0;
                if (b != magic_byte) begin
                    do_fail   = 1'b1;
                    fail_code = ST_MAGIC;
                end else if (byte_in_item_reg >= 3'd3) begin
                    byte_in_item_next = '0;
                    row_total_next    = '0;
                    phase_next        = PH_COUNT;
                end else begin
                    byte_in_item_next = byte_in_item_reg + 3'd1;
                end
            end
            PH_COUNT: begin
                result.byte_role    = ROLE_HEADER;
                result.row_number   = '0;
                result.field_number = '0;
                row_total_next      = count_full;
                if (byte_in_item_reg >= 3'd3) begin
                    byte_in_item_next = '0;
                    if (count_full > max_rows_reg) begin
                        do_fail   = 1'b1;
                        fail_code = ST_COUNT;
                    end else begin
                        row_pos_next   = '0;
                        field_pos_next = '0;
                        phase_next     = (count_full == 32'd0) ? PH_DONE : PH_FIELD;
                    end
                end else begin
                    byte_in_item_next = byte_in_item_reg + 3'd1;
                end
            end
            PH_FIELD: begin
                case (ftype) inside
                    FT_STR: begin
                        result.byte_role  = ROLE_TAG;
                        length_shift_next = {24'd0, b};
                        byte_in_item_next = 3'd1;
                        phase_next        = PH_LEN;
                    end
                    FT_NUM: begin
                        result.byte_role  = ROLE_CONTENT;
                        byte_in_item_next = 3'd1;
                        phase_next        = PH_NUM;
                    end
                    FT_BOOL, FT_NBOOL: begin
                        result.byte_role = ROLE_CONTENT;
                        if (b > ((ftype == FT_BOOL) ? 8'd1 : 8'd2)) begin
                            do_fail = 1'b1;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                    default: begin
                        result.byte_role = ROLE_TAG;
                        if (b > 8'd1) begin
                            do_fail = 1'b1;
                        end else if (b == 8'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            byte_in_item_next = '0;
                            length_shift_next = '0;
                            phase_next        = (ftype == FT_NSTR) ? PH_LEN : PH_NUM;
                        end
                    end
                endcase
            end
            PH_LEN: begin
                result.byte_role  = ROLE_TAG;
                length_shift_next = len_full;
                if (byte_in_item_reg >= 3'd3) begin
                    byte_in_item_next = '0;
                    string_left_next  = len_full;
                    if (len_full == 32'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        phase_next = PH_STR;
                    end
                end else begin
                    byte_in_item_next = byte_in_item_reg + 3'd1;
                end
            end
            PH_STR: begin
                result.byte_role = ROLE_CONTENT;
                string_left_next = str_dec;
                if (str_dec == 32'd0) begin
                    do_finish = 1'b1;
                end
            end
            PH_NUM: begin
                result.byte_role = ROLE_CONTENT;
                if (byte_in_item_reg >= 3'd7) begin
                    do_finish = 1'b1;
                end else begin
                    byte_in_item_next = byte_in_item_reg + 3'd1;
                end
            end
            PH_DONE: begin
                do_fail   = 1'b1;
                fail_code = ST_TRAIL;
            end
            default: begin
            end
        endcase

        if (do_fail) begin
            error_held_next = fail_code;
            phase_next      = PH_ERR;
        end else if (do_finish) begin
            byte_in_item_next = '0;
            if (fld_inc >= FIELDS_PER_ROW) begin
                field_pos_next = '0;
                row_pos_next   = row_inc;
                phase_next     = (row_inc == row_total_reg) ? PH_DONE : PH_FIELD;
            end else begin
                field_pos_next = fld_inc;
                phase_next     = PH_FIELD;
            end
        end

        if (phase_next == PH_ERR) begin
            result.status = error_held_next;
        end else if (last) begin
            case (phase_next)
                PH_DONE:  result.status = ST_OK;
                PH_MAGIC: result.status = ST_MAGIC;
                PH_COUNT: result.status = ST_COUNT;
                default:  result.status = ST_ROW;
            endcase
        end

        // rearm for the next payload
        if (last) begin
            phase_next        = PH_MAGIC;
            byte_in_item_next = '0;
            field_pos_next    = '0;
            string_left_next  = '0;
            length_shift_next = '0;
            row_pos_next      = '0;
            row_total_next    = '0;
            error_held_next   = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= MAGIC_WORD_RST;
            max_rows_reg   <= MAX_ROWS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAGIC_WORD: magic_word_reg <= cfg_wr_data;
                CFG_MAX_ROWS:   max_rows_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MAGIC;
            byte_in_item_reg <= '0;
            field_pos_reg    <= '0;
            string_left_reg  <= '0;
            length_shift_reg <= '0;
            row_pos_reg      <= '0;
            row_total_reg    <= '0;
            error_held_reg   <= ST_RUN;
        end else if (advance) begin
            phase_reg        <= phase_next;
            byte_in_item_reg <= byte_in_item_next;
            field_pos_reg    <= field_pos_next;
            string_left_reg  <= string_left_next;
            length_shift_reg <= length_shift_next;
            row_pos_reg      <= row_pos_next;
            row_total_reg    <= row_total_next;
            error_held_reg   <= error_held_next;
        end
    end

`ifndef SYNTH
    a_err_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ERR) |-> (error_held_reg != ST_RUN && error_held_reg != ST_OK))
        else $error("error phase without an error code");

    a_no_code_outside_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_ERR) |-> (error_held_reg == ST_RUN))
        else $error("error code held outside error phase");

    a_string_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STR) |-> (string_left_reg != 32'd0))
        else $error("string phase with no bytes left");

    a_field_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        field_pos_reg < FIELDS_PER_ROW)
        else $error("field position beyond row");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last) |=> (phase_reg == PH_MAGIC && row_pos_reg == 32'd0
                               && byte_in_item_reg == 3'd0))
        else $error("no rearm after end of payload");
`endif

endmodule

`default_nettype wire

### hw/rtl/rssv_out_reg.sv
`default_nettype none

module rssv_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire rssv_pkg::result_t result,
    output logic                   out_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rssv_pkg::result_t      m_result
);
    import rssv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/record_snapshot_stream_validator.sv
// channel | ports                                      | request moves
// s_      | s_valid s_ready s_data_byte s_end_of_payload | one payload byte
// m_      | m_valid m_ready m_status .. m_payload_done   | one verdict per byte
// cfg_    | cfg_wr_en cfg_index cfg_wr_data               | one register write
//
// one byte per cycle sustained while m_ready is high; a byte reaches m_ via the input then the result register
// the schedule check and counter updates sit between the input and result registers
// aresetn (synchronous) restores magic_word 0x31535452 and max_rows 1000000
// a stall on m_ holds the result; one byte waits in the input register
// state rearms after each end_of_payload byte, registers are kept
`default_nettype none

module record_snapshot_stream_validator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_row_number,
    output logic [5:0]       m_field_number,
    output logic [1:0]       m_byte_role,
    output logic [7:0]       m_byte_value,
    output logic             m_payload_done
);
    import rssv_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    advance;
    result_t result;
    result_t m_result;

    assign advance = item_valid && out_free;

    rssv_in_reg u_in_reg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_payload (s_end_of_payload),
        .advance          (advance),
        .item_valid       (item_valid),
        .item             (item)
    );

    rssv_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (item),
        .advance     (advance),
        .result      (result)
    );

    rssv_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_status       = m_result.status;
    assign m_row_number   = m_result.row_number;
    assign m_field_number = m_result.field_number;
    assign m_byte_role    = m_result.byte_role;
    assign m_byte_value   = m_result.byte_value;
    assign m_payload_done = m_result.payload_done;

endmodule

`default_nettype wire
